/* rtl/jdg_pkg.sv */
// ----------------------------------------------------------------------------
// jdg_pkg
// Shared types and constants for the Julian day to Gregorian date converter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package jdg_pkg;

  // pipeline depth, stage 1 takes the input, stage NSTG is the output register
  localparam int unsigned NSTG    = 17;
  // stage at which the time of day is complete
  localparam int unsigned TOD_STG = 7;

  localparam int unsigned HALF_DAY_MS  = 43200000;
  localparam int unsigned HOUR_MS      = 3600000;
  localparam int unsigned MINUTE_MS    = 60000;
  localparam int unsigned DAYS_4CENT   = 146097;
  localparam int unsigned DAYS_4YEAR   = 1461;
  localparam int unsigned MONTH_SPAN   = 153;
  localparam int unsigned DAY_SPAN     = 5;

  // 4 * (julian_day - 1721119) - 1 folds to 4 * julian_day - 6884477
  localparam logic signed [26:0] X1_BIAS = 27'sd6884477;

  // truncated reciprocals, each estimate is low by at most one
  localparam logic [7:0] REC_CENT  = 8'((2 ** 25) / DAYS_4CENT);
  localparam logic [7:0] REC_YEAR  = 8'((2 ** 18) / DAYS_4YEAR);
  localparam logic [3:0] REC_MONTH = 4'((2 ** 11) / MONTH_SPAN);
  localparam logic [5:0] REC_DAY   = 6'((2 ** 8) / DAY_SPAN);
  localparam logic [5:0] REC_HOUR  = 6'((2 ** 27) / HOUR_MS);
  localparam logic [6:0] REC_MIN   = 7'((2 ** 22) / MINUTE_MS);

  typedef struct packed {
    logic [22:0] julian_day;
    logic [26:0] day_fraction_ms;
  } jdg_in_t;

  typedef struct packed {
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day_of_month;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [15:0] second_ms;
  } jdg_out_t;

  typedef struct packed {
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day_of_month;
  } jdg_date_t;

  typedef struct packed {
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [15:0] second_ms;
  } jdg_tod_t;

  typedef struct packed {
    logic [NSTG:1] en;
  } jdg_ctl_t;

endpackage

/* rtl/jdg_ctrl.sv */
// ----------------------------------------------------------------------------
// jdg_ctrl
// Valid bits and per-stage load enables of the conversion pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module jdg_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              stall_o,
  output logic              valid_o,
  input  logic              stall_i,
  output jdg_pkg::jdg_ctl_t ctl_o
);
  import jdg_pkg::*;

  logic [NSTG:1] v_q, v_d;
  logic [NSTG:1] en;
  logic [NSTG:1] hole;
  logic [NSTG:1] v_prev;

  // a stage loads when the output moves or a bubble sits at or above it
  always_comb begin
    hole = ~v_q;
    for (int k = 1; k <= NSTG; k++) begin
      en[k] = !stall_i || (|(hole >> (k - 1)));
    end
  end

  always_comb begin
    v_prev = {v_q[NSTG-1:1], valid_i};
    v_d    = (en & v_prev) | (~en & v_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= v_d;
    end
  end

  assign ctl_o.en = en;
  assign stall_o  = !en[1];
  assign valid_o  = v_q[NSTG];

  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall_o |-> (stall_i && (&v_q)))
    else $error("input stalled while pipeline has a bubble");

  a_enter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_i && !stall_o) |=> v_q[1])
    else $error("accepted transaction missing from first stage");

  a_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> ($countones(v_q) == $past($countones(v_q))
                                + ($past(valid_i && !stall_o) ? 1 : 0)
                                - ($past(valid_o && !stall_i) ? 1 : 0)))
    else $error("transaction lost or duplicated in pipeline");

endmodule

/* rtl/jdg_date_pipe.sv */
// ----------------------------------------------------------------------------
// jdg_date_pipe
// Day number to year, month and day through four pipelined signed
// divisions by constants.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module jdg_date_pipe (
  input  logic               clk_i,
  input  jdg_pkg::jdg_ctl_t  ctl_i,
  input  jdg_pkg::jdg_in_t   in_item_i,
  output jdg_pkg::jdg_date_t date_o
);
  import jdg_pkg::*;

  // stage 1
  logic               carry;
  logic signed [26:0] x1_d, x1_q;
  // stage 2
  logic [24:0] a1_d, a1_q2;
  logic        n1_q2;
  // stage 3
  logic [32:0] p1;
  logic [24:0] a1_q3;
  logic [7:0]  q1e_q3;
  logic        n1_q3;
  // stage 4
  logic [25:0] t4;
  logic [18:0] r1e_q4;
  logic [7:0]  q1e_q4;
  logic        n1_q4;
  // stage 5
  logic               fix5;
  logic [7:0]         q1;
  logic [18:0]        r1u;
  logic signed [8:0]  qs5;
  logic signed [18:0] rs5;
  logic signed [8:0]  cent_q;
  logic signed [18:0] r1_q;
  // stage 6
  logic signed [18:0] r1adj, t6;
  logic signed [18:0] x2;
  logic [17:0]        a2_d, a2_q6;
  logic               n2_q6;
  logic [13:0]        c100_d, c100_q6;
  // stage 7
  logic [24:0] p2;
  logic [17:0] a2_q7;
  logic [6:0]  q2e_q7;
  logic        n2_q7;
  logic [13:0] c100_q7;
  // stage 8
  logic [17:0] t8;
  logic [11:0] r2e_q8;
  logic [6:0]  q2e_q8;
  logic        n2_q8;
  logic [13:0] c100_q8;
  // stage 9
  logic               fix9;
  logic [6:0]         q2;
  logic [11:0]        r2u;
  logic signed [7:0]  qs9;
  logic signed [11:0] rs9;
  logic signed [7:0]  yr_q;
  logic signed [11:0] r2_q;
  logic [13:0]        c100_q9;
  // stage 10
  logic signed [11:0] s10, s10a, dd3, x3;
  logic [10:0]        a3_d, a3_q10;
  logic               n3_q10;
  logic [13:0]        ysum_d, ysum_q10;
  // stage 11
  logic [14:0] p3;
  logic [10:0] a3_q11;
  logic [3:0]  q3e_q11;
  logic        n3_q11;
  logic [13:0] ysum_q11;
  // stage 12
  logic [10:0] t12;
  logic [8:0]  r3e_q12;
  logic [3:0]  q3e_q12;
  logic        n3_q12;
  logic [13:0] ysum_q12;
  // stage 13
  logic              fix13;
  logic [3:0]        q3;
  logic [8:0]        r3u;
  logic signed [4:0] qs13;
  logic signed [8:0] rs13;
  logic signed [4:0] mm_q;
  logic signed [8:0] r3_q;
  logic [13:0]       ysum_q13;
  // stage 14
  logic signed [8:0] x4;
  logic [7:0]        a4_d, a4_q14;
  logic              n4_q14;
  logic              late;
  logic [3:0]        month_d, month_q14;
  logic [13:0]       year_d, year_q14;
  // stage 15
  logic [12:0] p4;
  logic [7:0]  a4_q15;
  logic [4:0]  q4e_q15;
  logic        n4_q15;
  logic [3:0]  month_q15;
  logic [13:0] year_q15;
  // stage 16
  logic [7:0]  t16;
  logic [3:0]  r4e_q16;
  logic [4:0]  q4e_q16;
  logic        n4_q16;
  logic [3:0]  month_q16;
  logic [13:0] year_q16;
  // stage 17
  logic [4:0]  q4;
  logic [4:0]  dd_d;
  jdg_date_t   date_q;

  // half-day shift and century dividend
  always_comb begin
    carry = in_item_i.day_fraction_ms >= 27'(HALF_DAY_MS);
    x1_d  = $signed({2'b00, in_item_i.julian_day, 2'b00})
          + $signed({24'd0, carry, 2'b00}) - X1_BIAS;
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en[1]) begin
      x1_q <= x1_d;
    end
  end

  assign a1_d = x1_q[26] ? 25'(-x1_q) : x1_q[24:0];

  always_ff @(posedge clk_i) begin
    if (ctl_i.en[2]) begin
      a1_q2 <= a1_d;
      n1_q2 <= x1_q[26];
    end
  end

  assign p1 = 33'(a1_q2) * 33'(REC_CENT);

  always_ff @(posedge clk_i) begin
    if (ctl_i.en[3]) begin
      a1_q3  <= a1_q2;
      q1e_q3 <= p1[32:25];
      n1_q3  <= n1_q2;
    end
  end

  assign t4 = 26'(a1_q3) - 26'(q1e_q3) * 26'(DAYS_4CENT);

  always_ff @(posedge clk_i) begin
    if (ctl_i.en[4]) begin
      r1e_q4 <= t4[18:0];
      q1e_q4 <= q1e_q3;
      n1_q4  <= n1_q3;
    end
  end

  always_comb begin
    fix5 = r1e_q4 >= 19'(DAYS_4CENT);
    q1   = fix5 ? q1e_q4 + 8'd1 : q1e_q4;
    r1u  = fix5 ? r1e_q4 - 19'(DAYS_4CENT) : r1e_q4;
    qs5  = $signed({1'b0, q1});
    rs5  = $signed(r1u);
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en[5]) begin
      cent_q <= n1_q4 ? -qs5 : qs5;
      r1_q   <= n1_q4 ? -rs5 : rs5;
    end
  end

  // year-in-century dividend, 4 * trunc(r / 4) + 3
  always_comb begin
    r1adj  = r1_q + (r1_q[18] ? 19'sd3 : 19'sd0);
    t6     = r1adj >>> 2;
    x2     = $signed({t6[16:0], 2'b11});
    a2_d   = x2[18] ? 18'(-x2) : x2[17:0];
    c100_d = 14'({{5{cent_q[8]}}, cent_q} * 14'd100);
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en[6]) begin
      a2_q6   <= a2_d;
      n2_q6   <= x2[18];
      c100_q6 <= c100_d;
    end
  end

  assign p2 = 25'(a2_q6) * 25'(REC_YEAR);

  always_ff @(posedge clk_i) begin
    if (ctl_i.en[7]) begin
      a2_q7   <= a2_q6;
      q2e_q7  <= p2[24:18];
      n2_q7   <= n2_q6;
      c100_q7 <= c100_q6;
    end
  end

  assign t8 = a2_q7 - 18'(q2e_q7) * 18'(DAYS_4YEAR);

  always_ff @(posedge clk_i) begin
    if (ctl_i.en[8]) begin
      r2e_q8  <= t8[11:0];
      q2e_q8  <= q2e_q7;
      n2_q8   <= n2_q7;
      c100_q8 <= c100_q7;
    end
  end

  always_comb begin
    fix9 = r2e_q8 >= 12'(DAYS_4YEAR);
    q2   = fix9 ? q2e_q8 + 7'd1 : q2e_q8;
    r2u  = fix9 ? r2e_q8 - 12'(DAYS_4YEAR) : r2e_q8;
    qs9  = $signed({1'b0, q2});
    rs9  = $signed(r2u);
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en[9]) begin
      yr_q    <= n2_q8 ? -qs9 : qs9;
      r2_q    <= n2_q8 ? -rs9 : rs9;
      c100_q9 <= c100_q8;
    end
  end

  // month dividend, 5 * trunc((r + 4) / 4) - 3
  always_comb begin
    s10    = r2_q + 12'sd4;
    s10a   = s10 + (s10[11] ? 12'sd3 : 12'sd0);
    dd3    = s10a >>> 2;
    x3     = (dd3 <<< 2) + dd3 - 12'sd3;
    a3_d   = x3[11] ? 11'(-x3) : x3[10:0];
    ysum_d = c100_q9 + {{6{yr_q[7]}}, yr_q};
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en[10]) begin
      a3_q10   <= a3_d;
      n3_q10   <= x3[11];
      ysum_q10 <= ysum_d;
    end
  end

  assign p3 = 15'(a3_q10) * 15'(REC_MONTH);

  always_ff @(posedge clk_i) begin
    if (ctl_i.en[11]) begin
      a3_q11   <= a3_q10;
      q3e_q11  <= p3[14:11];
      n3_q11   <= n3_q10;
      ysum_q11 <= ysum_q10;
    end
  end

  assign t12 = a3_q11 - 11'(q3e_q11) * 11'(MONTH_SPAN);

  always_ff @(posedge clk_i) begin
    if (ctl_i.en[12]) begin
      r3e_q12  <= t12[8:0];
      q3e_q12  <= q3e_q11;
      n3_q12   <= n3_q11;
      ysum_q12 <= ysum_q11;
    end
  end

  always_comb begin
    fix13 = r3e_q12 >= 9'(MONTH_SPAN);
    q3    = fix13 ? q3e_q12 + 4'd1 : q3e_q12;
    r3u   = fix13 ? r3e_q12 - 9'(MONTH_SPAN) : r3e_q12;
    qs13  = $signed({1'b0, q3});
    rs13  = $signed(r3u);
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en[13]) begin
      mm_q     <= n3_q12 ? -qs13 : qs13;
      r3_q     <= n3_q12 ? -rs13 : rs13;
      ysum_q13 <= ysum_q12;
    end
  end

  // day dividend and march-based month folded to january-based
  always_comb begin
    x4      = r3_q + 9'sd5;
    a4_d    = x4[8] ? 8'(-x4) : x4[7:0];
    late    = mm_q >= 5'sd10;
    month_d = late ? 4'(mm_q - 5'sd9) : 4'(mm_q + 5'sd3);
    year_d  = ysum_q13 + {13'd0, late};
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en[14]) begin
      a4_q14    <= a4_d;
      n4_q14    <= x4[8];
      month_q14 <= month_d;
      year_q14  <= year_d;
    end
  end

  assign p4 = 13'(a4_q14) * 13'(REC_DAY);

  always_ff @(posedge clk_i) begin
    if (ctl_i.en[15]) begin
      a4_q15    <= a4_q14;
      q4e_q15   <= p4[12:8];
      n4_q15    <= n4_q14;
      month_q15 <= month_q14;
      year_q15  <= year_q14;
    end
  end

  assign t16 = a4_q15 - 8'(q4e_q15) * 8'(DAY_SPAN);

  always_ff @(posedge clk_i) begin
    if (ctl_i.en[16]) begin
      r4e_q16   <= t16[3:0];
      q4e_q16   <= q4e_q15;
      n4_q16    <= n4_q15;
      month_q16 <= month_q15;
      year_q16  <= year_q15;
    end
  end

  always_comb begin
    q4   = (r4e_q16 >= 4'(DAY_SPAN)) ? q4e_q16 + 5'd1 : q4e_q16;
    dd_d = n4_q16 ? 5'(-q4) : q4;
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en[17]) begin
      date_q.year         <= year_q16;
      date_q.month        <= month_q16;
      date_q.day_of_month <= dd_d;
    end
  end

  assign date_o = date_q;

endmodule

/* rtl/jdg_time_pipe.sv */
// ----------------------------------------------------------------------------
// jdg_time_pipe
// Day fraction to hour, minute and milliseconds, delayed to line up with
// the date.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module jdg_time_pipe (
  input  logic              clk_i,
  input  jdg_pkg::jdg_ctl_t ctl_i,
  input  logic [26:0]       day_fraction_ms_i,
  output jdg_pkg::jdg_tod_t tod_o
);
  import jdg_pkg::*;

  logic        carry;
  logic [26:0] fa_d, fa_q1, fa_q2;
  logic [31:0] ph;
  logic [4:0]  hqe_q2, hqe_q3;
  logic [26:0] t3;
  logic [22:0] re_q3;
  logic        fixh;
  logic [4:0]  hr_d, hr_q4, hr_q5, hr_q6;
  logic [21:0] rem_d, rem_q4, rem_q5;
  logic [27:0] pm;
  logic [5:0]  mqe_q5, mqe_q6;
  logic [21:0] t6;
  logic [16:0] re2_q6;
  logic        fixm;
  jdg_tod_t    tod_d;
  jdg_tod_t    tod_q [TOD_STG:NSTG];

  // shift the start of the day from noon to midnight
  always_comb begin
    carry = day_fraction_ms_i >= 27'(HALF_DAY_MS);
    fa_d  = carry ? day_fraction_ms_i - 27'(HALF_DAY_MS)
                  : day_fraction_ms_i + 27'(HALF_DAY_MS);
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en[1]) begin
      fa_q1 <= fa_d;
    end
  end

  assign ph = 32'(fa_q1) * 32'(REC_HOUR);

  always_ff @(posedge clk_i) begin
    if (ctl_i.en[2]) begin
      fa_q2  <= fa_q1;
      hqe_q2 <= ph[31:27];
    end
  end

  assign t3 = fa_q2 - 27'(hqe_q2) * 27'(HOUR_MS);

  always_ff @(posedge clk_i) begin
    if (ctl_i.en[3]) begin
      re_q3  <= t3[22:0];
      hqe_q3 <= hqe_q2;
    end
  end

  always_comb begin
    fixh  = re_q3 >= 23'(HOUR_MS);
    hr_d  = fixh ? hqe_q3 + 5'd1 : hqe_q3;
    rem_d = fixh ? 22'(re_q3 - 23'(HOUR_MS)) : re_q3[21:0];
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en[4]) begin
      hr_q4  <= hr_d;
      rem_q4 <= rem_d;
    end
  end

  assign pm = 28'(rem_q4) * 28'(REC_MIN);

  always_ff @(posedge clk_i) begin
    if (ctl_i.en[5]) begin
      hr_q5  <= hr_q4;
      rem_q5 <= rem_q4;
      mqe_q5 <= pm[27:22];
    end
  end

  assign t6 = rem_q5 - 22'(mqe_q5) * 22'(MINUTE_MS);

  always_ff @(posedge clk_i) begin
    if (ctl_i.en[6]) begin
      hr_q6  <= hr_q5;
      mqe_q6 <= mqe_q5;
      re2_q6 <= t6[16:0];
    end
  end

  always_comb begin
    fixm            = re2_q6 >= 17'(MINUTE_MS);
    tod_d.hour      = hr_q6;
    tod_d.minute    = fixm ? mqe_q6 + 6'd1 : mqe_q6;
    tod_d.second_ms = fixm ? 16'(re2_q6 - 17'(MINUTE_MS)) : re2_q6[15:0];
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en[TOD_STG]) begin
      tod_q[TOD_STG] <= tod_d;
    end
  end

  for (genvar k = TOD_STG + 1; k <= NSTG; k++) begin : g_delay
    always_ff @(posedge clk_i) begin
      if (ctl_i.en[k]) begin
        tod_q[k] <= tod_q[k-1];
      end
    end
  end

  assign tod_o = tod_q[NSTG];

endmodule

/* rtl/julian_day_to_gregorian_date.sv */
// ----------------------------------------------------------------------------
// julian_day_to_gregorian_date
// An accepted transaction passes through 17 register stages before its result
// can be taken at the output.
// Throughput: one transaction per cycle unless the output stalls; every stage advances when the output moves.
// Empty stages fill while the output is stalled; input stalls only when full.
// Reset clears all stage valid bits; the data registers are not reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module julian_day_to_gregorian_date (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              stall_o,
  input  jdg_pkg::jdg_in_t  in_item_i,
  output logic              valid_o,
  input  logic              stall_i,
  output jdg_pkg::jdg_out_t out_item_o
);
  import jdg_pkg::*;

  jdg_ctl_t  ctl;
  jdg_date_t date;
  jdg_tod_t  tod;

  jdg_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (valid_i),
    .stall_o (stall_o),
    .valid_o (valid_o),
    .stall_i (stall_i),
    .ctl_o   (ctl)
  );

  jdg_date_pipe u_date (
    .clk_i     (clk_i),
    .ctl_i     (ctl),
    .in_item_i (in_item_i),
    .date_o    (date)
  );

  jdg_time_pipe u_time (
    .clk_i             (clk_i),
    .ctl_i             (ctl),
    .day_fraction_ms_i (in_item_i.day_fraction_ms),
    .tod_o             (tod)
  );

  always_comb begin
    out_item_o.year         = date.year;
    out_item_o.month        = date.month;
    out_item_o.day_of_month = date.day_of_month;
    out_item_o.hour         = tod.hour;
    out_item_o.minute       = tod.minute;
    out_item_o.second_ms    = tod.second_ms;
  end

endmodule
